>>> src/indexed_list_store_macros.svh
// Assertion macros for the indexed list store.
// Sampled on clock, disabled while reset is high; no other dependencies.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// same-cycle implication
`define ILST_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ilst_pkg.sv
// Shared types and constants for the indexed list store.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilst_pkg;

   localparam int KIND_W   = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   // null mark stored beside each word
   localparam logic ENTRY_NULL = 1'b1;
   localparam logic ENTRY_LIVE = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ   = 2'd0,
      KIND_ASSIGN = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NEG_INDEX = 2'd1,
      STATUS_CAPACITY  = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic stream;
      logic pad;
      logic word;
      logic respond;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic err;
      logic hit;
      logic access;
      logic insert;
      logic stream_done;
      logic pad_done;
   } ctl_status_type;

endpackage

`default_nettype wire

>>> src/ilst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ilst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/ilst_ctrl.sv
// Transaction sequencer for the indexed list store.
// Depends on ilst_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ilst_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire ilst_pkg::ctl_status_type stat,
   output ilst_pkg::ctl_cmd_type        cmd
);

   import ilst_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_STREAM   = 6'b000100,
      ST_PAD      = 6'b001000,
      ST_WORD     = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (stat.err) begin
               state_in = ST_RESP;
            end else if (stat.access) begin
               state_in = stat.hit ? ST_STREAM : ST_RESP;
            end else if (stat.hit) begin
               state_in = stat.insert ? ST_STREAM : ST_WORD;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_STREAM: begin
            cmd.stream = 1'b1;
            if (stat.stream_done) begin
               state_in = stat.insert ? ST_WORD : ST_RESP;
            end
         end
         ST_PAD: begin
            if (stat.pad_done) begin
               state_in = ST_WORD;
            end else begin
               cmd.pad = 1'b1;
            end
         end
         ST_WORD: begin
            cmd.word = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> src/ilst_datapath.sv
// Datapath for the indexed list store: request decode, fill count, pointers,
// entry RAM and result registers. Depends on ilst_pkg and ilst_ram.
`timescale 1ns / 1ps
`default_nettype none

module ilst_datapath #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ilst_pkg::ctl_cmd_type           cmd,
   output ilst_pkg::ctl_status_type             stat,
   input  wire logic [ilst_pkg::KIND_W-1:0]     req_type,
   input  wire logic signed [ilst_pkg::POS_W-1:0] req_position,
   input  wire logic [ilst_pkg::VALUE_W-1:0]    req_write_value,
   output logic                                 rsp_valid,
   output logic [ilst_pkg::VALUE_W-1:0]         rsp_read_value,
   output logic                                 rsp_is_null,
   output logic [ilst_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ilst_pkg::FILL_W-1:0]          rsp_fill_count
);

   import ilst_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int UW     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int EW     = UW + 2;
   localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

   // request decode against the current fill count
   kind_type        req_kind;
   logic [EW-1:0]   pos_ext;
   logic [EW-1:0]   cnt_ext;
   logic [EW-1:0]   idx;
   logic [EW-1:0]   need;
   logic [EW-1:0]   span;
   logic            dec_neg;
   logic            dec_hit;
   logic            dec_access;
   logic            dec_store;
   logic            dec_cap;

   // held request
   kind_type              kind_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [ADDR_W-1:0]     u_ff;
   logic                  hit_ff;
   logic                  neg_ff;
   logic                  cap_ff;
   logic [CNT_W-1:0]      need_ff;

   // control state
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      reads_left_ff;
   logic                  pend_ff;
   logic                  first_ff;
   logic                  rsp_valid_ff;
   logic [ADDR_W-1:0]     rd_ptr_ff;
   logic [ADDR_W-1:0]     wr_ptr_ff;

   // result
   logic [VALUE_W-1:0]    val_ff;
   logic                  nul_ff;
   logic [VALUE_W-1:0]    cap_val;

   // RAM ports
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_BITS:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [WORD_BITS:0]    ram_rd_data;

   logic                  req_ok;
   logic                  move_wr;

   assign req_kind   = kind_type'(req_type);
   assign pos_ext    = {{(EW-POS_W){req_position[POS_W-1]}}, req_position};
   assign cnt_ext    = {{(EW-CNT_W){1'b0}}, count_ff};
   assign idx        = req_position[POS_W-1] ? (pos_ext + cnt_ext) : pos_ext;
   assign dec_neg    = idx[EW-1];
   assign dec_hit    = (idx < cnt_ext);
   assign dec_access = (req_kind == KIND_READ) || (req_kind == KIND_DELETE);
   assign dec_store  = !dec_access;
   assign span       = cnt_ext - idx;

   always_comb begin
      if (dec_hit) begin
         need = (req_kind == KIND_INSERT) ? (cnt_ext + EW'(1)) : cnt_ext;
      end else begin
         need = idx + EW'(1);
      end
   end

   assign dec_cap = !dec_neg && dec_store && (need > CAP_E);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         word_ff  <= req_write_value[WORD_BITS-1:0];
         u_ff     <= idx[ADDR_W-1:0];
         hit_ff   <= dec_hit;
         neg_ff   <= dec_neg;
         cap_ff   <= dec_cap;
         need_ff  <= need[CNT_W-1:0];
         first_ff <= dec_access;
         val_ff   <= '0;
         nul_ff   <= dec_access && !dec_hit && !dec_neg;
         if (req_kind == KIND_INSERT) begin
            rd_ptr_ff <= count_ff[ADDR_W-1:0] - ADDR_W'(1);
         end else begin
            rd_ptr_ff <= idx[ADDR_W-1:0];
         end
         wr_ptr_ff <= dec_access ? idx[ADDR_W-1:0] : count_ff[ADDR_W-1:0];
      end else begin
         if (cmd.stream) begin
            if (reads_left_ff != '0) begin
               if (kind_ff == KIND_INSERT) begin
                  rd_ptr_ff <= rd_ptr_ff - ADDR_W'(1);
               end else begin
                  rd_ptr_ff <= rd_ptr_ff + ADDR_W'(1);
               end
            end
            if (pend_ff) begin
               if (first_ff) begin
                  first_ff <= 1'b0;
                  val_ff   <= cap_val;
                  nul_ff   <= (ram_rd_data[WORD_BITS] == ENTRY_NULL);
               end else if (kind_ff == KIND_INSERT) begin
                  wr_ptr_ff <= wr_ptr_ff - ADDR_W'(1);
               end else begin
                  wr_ptr_ff <= wr_ptr_ff + ADDR_W'(1);
               end
            end
         end
         if (cmd.pad) begin
            wr_ptr_ff <= wr_ptr_ff + ADDR_W'(1);
         end
      end
   end

   // reads to stream: one for a read, the tail from the index for delete or insert
   always_ff @(posedge clock) begin
      if (reset) begin
         reads_left_ff <= '0;
         pend_ff       <= 1'b0;
      end else if (cmd.load) begin
         pend_ff <= 1'b0;
         if (!dec_neg && !dec_cap && dec_hit && (req_kind != KIND_ASSIGN)) begin
            reads_left_ff <= (req_kind == KIND_READ) ? CNT_W'(1) : span[CNT_W-1:0];
         end else begin
            reads_left_ff <= '0;
         end
      end else if (cmd.stream) begin
         pend_ff <= (reads_left_ff != '0);
         if (reads_left_ff != '0) begin
            reads_left_ff <= reads_left_ff - CNT_W'(1);
         end
      end
   end

   assign req_ok = !neg_ff && !cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.respond && req_ok) begin
            if (kind_ff == KIND_DELETE) begin
               if (hit_ff) begin
                  count_ff <= count_ff - CNT_W'(1);
               end
            end else if (kind_ff != KIND_READ) begin
               count_ff <= need_ff;
            end
         end
      end
   end

   always_comb begin
      cap_val = '0;
      if (ram_rd_data[WORD_BITS] == ENTRY_LIVE) begin
         cap_val[WORD_BITS-1:0] = ram_rd_data[WORD_BITS-1:0];
      end
   end

   assign move_wr   = cmd.stream && pend_ff && !first_ff;
   assign ram_rd_en = cmd.stream && (reads_left_ff != '0);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_ptr_ff;
      ram_wr_data = ram_rd_data;
      priority if (move_wr) begin
         ram_wr_en = 1'b1;
      end else if (cmd.pad) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = {ENTRY_NULL, {WORD_BITS{1'b0}}};
      end else if (cmd.word) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = u_ff;
         ram_wr_data = {ENTRY_LIVE, word_ff};
      end else begin
         ram_wr_en = 1'b0;
      end
   end

   ilst_ram #(
      .WIDTH (WORD_BITS + 1),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign stat.err         = neg_ff || cap_ff;
   assign stat.hit         = hit_ff;
   assign stat.access      = (kind_ff == KIND_READ) || (kind_ff == KIND_DELETE);
   assign stat.insert      = (kind_ff == KIND_INSERT);
   assign stat.stream_done = (reads_left_ff == '0) && !pend_ff;
   assign stat.pad_done    = (wr_ptr_ff == u_ff);

   always_comb begin
      priority if (neg_ff) begin
         rsp_status = STATUS_NEG_INDEX;
      end else if (cap_ff) begin
         rsp_status = STATUS_CAPACITY;
      end else begin
         rsp_status = STATUS_OK;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = val_ff;
   assign rsp_is_null    = nul_ff;
   assign rsp_fill_count = cnt_ext[FILL_W-1:0];

endmodule

`default_nettype wire

>>> src/indexed_list_store.sv
// Top level of the indexed list store: controller plus datapath.
// Depends on ilst_pkg, ilst_ctrl, ilst_datapath and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

// Bounded list of up to CAPACITY words with a fill count. A transaction is
// accepted when start is high and busy is low; each one returns exactly one
// result, shown for a single cycle with rsp_valid high. The receiver cannot
// stall, so capture the rsp_ fields whenever rsp_valid is seen. Positions are
// signed: a negative one counts back from the fill count. Errors, and reads
// or deletes past the end, go from dispatch straight to the response; a read
// hit streams one entry; an assign in range writes its word; a delete streams
// the tail down from the index and an insert streams it up before writing
// the word; padding past the end writes null entries up to the index before
// the word. The entry RAM has one read and one write port, so the tail moves
// or pads by one entry per cycle. The fill count reported is the low seven
// bits of the count after the transaction.
module indexed_list_store #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [ilst_pkg::KIND_W-1:0]         req_type,
   input  wire logic signed [ilst_pkg::POS_W-1:0]   req_position,
   input  wire logic [ilst_pkg::VALUE_W-1:0]        req_write_value,
   // response
   output logic                                     rsp_valid,
   output logic [ilst_pkg::VALUE_W-1:0]             rsp_read_value,
   output logic                                     rsp_is_null,
   output logic [ilst_pkg::STATUS_W-1:0]            rsp_status,
   output logic [ilst_pkg::FILL_W-1:0]              rsp_fill_count
);

   import ilst_pkg::*;

   // command and status between the sequencer and the datapath
   ctl_cmd_type    cmd;
   ctl_status_type stat;

   // sequencer: decides per transaction whether to stream, pad, write, respond
   ilst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath: decode, pointers, entry RAM, fill count and result registers
   ilst_datapath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_is_null     (rsp_is_null),
      .rsp_status      (rsp_status),
      .rsp_fill_count  (rsp_fill_count)
   );

`include "indexed_list_store_macros.svh"

   // a response is shown only once the sequencer is back to idle
   `ILST_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy, "response while busy")
   // every response follows a busy stretch
   `ILST_ASSERT_SAME(a_rsp_after_busy, rsp_valid, $past(busy), "response without work")
   // an accepted transaction makes the block busy
   `ILST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not start work")
   // null results and errors carry no word
   `ILST_ASSERT_SAME(a_null_clean, rsp_valid && rsp_is_null,
      (rsp_read_value == '0) && (rsp_status == STATUS_OK), "null result carries data")
   `ILST_ASSERT_SAME(a_err_clean, rsp_valid && (rsp_status != STATUS_OK),
      (rsp_read_value == '0) && !rsp_is_null, "error result carries data")

endmodule

`default_nettype wire
